// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros for the averager design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== design/spad_pkg.sv =====
// ----------------------------------------------------------------------------
// spad_pkg
// Shared types and constants for the spectrum power averager.
// ----------------------------------------------------------------------------
`default_nettype none
package spad_pkg;
  localparam int LOG2_FFT_MAX = 12;
  localparam int AVG_MAX      = 1024;
  localparam int SUM_W        = 42;
  localparam int CFG_IDX_W    = 1;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_FACTOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG2_FFT   = 1'b1;

  typedef struct packed {
    logic signed [15:0] bin_re;
    logic signed [15:0] bin_im;
    logic [35:0]        center_freq;
  } spad_in_t;

  typedef struct packed {
    logic signed [15:0] psd_db;
    logic [11:0]        bin_index;
    logic [35:0]        seg_center_freq;
    logic               last_bin;
  } spad_out_t;

  // Control carried alongside a bin through the log pipeline.
  typedef struct packed {
    logic        emit;
    logic [11:0] idx;
    logic [35:0] freq;
    logic        last;
  } spad_tag_t;
endpackage
`default_nettype wire

// ===== design/spad_ram.sv =====
// ----------------------------------------------------------------------------
// spad_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module spad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/spad_log.sv =====
// ----------------------------------------------------------------------------
// spad_log
// Pipelined 10*log10(sum/avg) in 1/256 dB; one squaring stage per fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none
module spad_log (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_vld,
  input  wire logic [spad_pkg::SUM_W-1:0] in_sum,
  input  wire logic [10:0]               in_avg,
  input  wire spad_pkg::spad_tag_t       in_tag,
  output logic                           out_vld,
  output spad_pkg::spad_out_t            out_res
);
  import spad_pkg::*;
  localparam int NS = 16;

  // Stage 0: normalize sum and avg into exponent and Q30 mantissa.
  logic              v_r   [NS+3];
  spad_tag_t         t_r   [NS+3];
  logic              z_r   [NS+3];
  logic [5:0]        es_r  [NS+1];
  logic [3:0]        ea_r  [NS+1];
  logic [30:0]       ms_r  [NS+1];
  logic [30:0]       ma_r  [NS+1];
  logic [15:0]       fs_r  [NS+1];
  logic [15:0]       fa_r  [NS+1];
  logic signed [22:0] d_r;
  logic signed [48:0] q_r;
  logic [5:0]        es_c;
  logic [3:0]        ea_c;
  logic [SUM_W+29:0] shs;
  logic [40:0]       sha;

  always_comb begin
    es_c = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (in_sum[i]) es_c = 6'(i);
    end
    ea_c = '0;
    for (int i = 0; i < 11; i++) begin
      if (in_avg[i]) ea_c = 4'(i);
    end
    shs = ({30'b0, in_sum} << 30) >> es_c;
    sha = ({30'b0, in_avg} << 30) >> ea_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS+3; k++) v_r[k] <= 1'b0;
    end else begin
      v_r[0] <= in_vld;
      for (int k = 1; k < NS+3; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    t_r[0]  <= in_tag;
    z_r[0]  <= (in_sum == '0);
    es_r[0] <= es_c;
    ea_r[0] <= ea_c;
    ms_r[0] <= shs[30:0];
    ma_r[0] <= sha[30:0];
    fs_r[0] <= '0;
    fa_r[0] <= '0;
    for (int k = 1; k < NS+3; k++) begin
      t_r[k] <= t_r[k-1];
      z_r[k] <= z_r[k-1];
    end
  end

  // Squaring stages: two 31x31 products per stage, registered.
  for (genvar g = 0; g < NS; g++) begin : g_sq
    logic [61:0] ps, pa;
    logic [31:0] ss, sa;
    always_comb begin
      ps = 62'(ms_r[g]) * 62'(ms_r[g]);
      pa = 62'(ma_r[g]) * 62'(ma_r[g]);
      ss = ps[61:30];
      sa = pa[61:30];
    end
    always_ff @(posedge clk) begin
      es_r[g+1] <= es_r[g];
      ea_r[g+1] <= ea_r[g];
      fs_r[g+1] <= {fs_r[g][14:0], ss[31]};
      fa_r[g+1] <= {fa_r[g][14:0], sa[31]};
      ms_r[g+1] <= ss[31] ? ss[31:1] : ss[30:0];
      ma_r[g+1] <= sa[31] ? sa[31:1] : sa[30:0];
    end
  end

  logic signed [48:0] qq;
  always_comb begin
    qq = 49'(d_r) * 49'sd50504433 + 49'sd2147483648;
  end

  always_ff @(posedge clk) begin
    d_r <= $signed({1'b0, es_r[NS], fs_r[NS]}) - $signed({3'b0, ea_r[NS], fa_r[NS]});
    q_r <= qq;
  end

  logic signed [16:0] rq;
  always_comb begin
    rq = 17'(q_r >>> 32);
    out_vld = v_r[NS+2] && t_r[NS+2].emit;
    out_res.bin_index       = t_r[NS+2].idx;
    out_res.seg_center_freq = t_r[NS+2].freq;
    out_res.last_bin        = t_r[NS+2].last;
    priority if (z_r[NS+2] || rq < -17'sd25600) begin
      out_res.psd_db = -16'sd25600;
    end else if (rq > 17'sd25600) begin
      out_res.psd_db = 16'sd25600;
    end else begin
      out_res.psd_db = rq[15:0];
    end
  end
endmodule
`default_nettype wire

// ===== design/spad_acc.sv =====
// ----------------------------------------------------------------------------
// spad_acc
// Bin and segment sequencing with read-modify-write of the power sums.
// ----------------------------------------------------------------------------
`default_nettype none
module spad_acc (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       take,
  input  wire spad_pkg::spad_in_t         in_item,
  input  wire logic                       restart,
  input  wire logic [10:0]                avg,
  input  wire logic [3:0]                 lg,
  output logic                            res_vld,
  output logic [spad_pkg::SUM_W-1:0]      res_sum,
  output spad_pkg::spad_tag_t             res_tag
);
  import spad_pkg::*;
  logic [12:0] bin_r, bin_nxt;
  logic [10:0] seg_r, seg_nxt;
  logic [35:0] gf_r, gf_nxt;
  logic        mm_r, mm_nxt;
  logic        s1_r;
  logic        s1_first_r;
  logic [11:0] s1_idx_r;
  logic [32:0] s1_p_r;
  spad_tag_t   s1_tag_r;
  logic [SUM_W-1:0] rdata, wsum;
  logic [12:0] size;
  logic [11:0] idx;
  logic [10:0] seg;
  logic        lastseg, lastb, mm_now;
  logic [31:0] pre, pim;

  always_comb begin
    size = 13'd1 << lg;
    idx  = (bin_r >= size) ? 12'd0 : bin_r[11:0];
    seg  = (seg_r >= avg) ? 11'd0 : seg_r;
    lastseg = (seg == avg - 11'd1);
    lastb   = ({1'b0, idx} == size - 13'd1);
    gf_nxt = gf_r;
    mm_now = mm_r;
    if (idx == 12'd0) begin
      if (seg == 11'd0) begin
        gf_nxt = in_item.center_freq;
        mm_now = 1'b0;
      end else if (in_item.center_freq != gf_r) begin
        mm_now = 1'b1;
      end
    end
    if (lastb) begin
      bin_nxt = '0;
      seg_nxt = lastseg ? 11'd0 : seg + 11'd1;
      mm_nxt  = lastseg ? 1'b0 : mm_now;
    end else begin
      bin_nxt = {1'b0, idx} + 13'd1;
      seg_nxt = seg;
      mm_nxt  = mm_now;
    end
    pre = 32'($signed(in_item.bin_re) * $signed(in_item.bin_re));
    pim = 32'($signed(in_item.bin_im) * $signed(in_item.bin_im));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r <= '0;
      seg_r <= '0;
      gf_r  <= '0;
      mm_r  <= 1'b0;
      s1_r  <= 1'b0;
    end else begin
      s1_r <= take;
      if (take) begin
        bin_r <= bin_nxt;
        seg_r <= seg_nxt;
        gf_r  <= gf_nxt;
        mm_r  <= mm_nxt;
      end else if (restart) begin
        bin_r <= '0;
        seg_r <= '0;
        mm_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= (seg == 11'd0);
    s1_idx_r   <= idx;
    s1_p_r     <= {1'b0, pre} + {1'b0, pim};
    s1_tag_r.emit <= lastseg && !mm_now;
    s1_tag_r.idx  <= idx;
    s1_tag_r.freq <= gf_nxt;
    s1_tag_r.last <= lastb;
  end

  // One item per transaction in flight; each bin address is touched once
  // per segment so the read after a write always sees the update.
  assign wsum = s1_first_r ? SUM_W'(s1_p_r) : rdata + SUM_W'(s1_p_r);

  spad_ram #(.WIDTH(SUM_W), .DEPTH(1 << LOG2_FFT_MAX)) u_ram (
    .clk  (clk),
    .we   (s1_r),
    .waddr(s1_idx_r),
    .wdata(wsum),
    .raddr(idx),
    .rdata(rdata)
  );

  assign res_vld = s1_r;
  assign res_sum = wsum;
  assign res_tag = s1_tag_r;
endmodule
`default_nettype wire

// ===== design/spectrum_power_averager_db.sv =====
// ----------------------------------------------------------------------------
// spectrum_power_averager_db
// Averages FFT bin power over segments and reports it in 1/256 dB.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake        Payload
// in_       input      valid / stall    spad_in_t
// out_      output     valid / stall    spad_out_t
// cfg_      input      valid / ready    index, data
//
// Only one transaction is in flight at a time: the item is read,
// accumulated in the sum RAM (registered read) and then runs through
// a 19-stage log pipeline into the output register, and the input stays
// stalled until that pipeline has drained.
// The sum RAM is not cleared; the first segment of a group writes each bin.
// A stalled result holds in the output register; no new item enters then.
// Reset is synchronous and active low.
`default_nettype none
`include "assert_macros.svh"
module spectrum_power_averager_db (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire spad_pkg::spad_in_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output spad_pkg::spad_out_t       out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [10:0]          cfg_data
);
  import spad_pkg::*;
  localparam logic [4:0] LAT = 5'd21;

  logic [10:0] avg_r;
  logic [3:0]  lg_r;
  logic [10:0] avg_eff;
  logic [3:0]  lg_eff;
  logic        busy_r;
  logic [4:0]  cnt_r;
  logic        take, cfg_wr, known;
  logic        acc_vld, log_vld;
  logic [SUM_W-1:0] acc_sum;
  spad_tag_t   acc_tag;
  spad_out_t   log_res;
  logic        ov_r;
  spad_out_t   od_r;

  // Clamp registers into their working ranges.
  always_comb begin
    avg_eff = (avg_r == 11'd0) ? 11'd1 : (avg_r > 11'(AVG_MAX) ? 11'(AVG_MAX) : avg_r);
    lg_eff  = (lg_r < 4'd4) ? 4'd4 : (lg_r > 4'(LOG2_FFT_MAX) ? 4'(LOG2_FFT_MAX) : lg_r);
  end

  assign in_stall  = busy_r || ov_r;
  assign take      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign known     = (cfg_index[1] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= 11'd1;
      lg_r  <= 4'd10;
    end else if (cfg_wr && known) begin
      if (cfg_index[0] == REG_AVG_FACTOR) begin
        avg_r <= cfg_data;
      end else begin
        lg_r <= cfg_data[3:0];
      end
    end
  end

  // Item occupancy: busy from accept until the log pipeline drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (take) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == LAT) busy_r <= 1'b0;
    end
  end

  spad_acc u_acc (
    .clk(clk), .rst_n(rst_n), .take(take), .in_item(in_data),
    .restart(cfg_wr && known), .avg(avg_eff), .lg(lg_eff),
    .res_vld(acc_vld), .res_sum(acc_sum), .res_tag(acc_tag)
  );

  spad_log u_log (
    .clk(clk), .rst_n(rst_n), .in_vld(acc_vld), .in_sum(acc_sum),
    .in_avg(avg_eff), .in_tag(acc_tag), .out_vld(log_vld), .out_res(log_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (log_vld) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (log_vld) od_r <= log_res;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  `ASSERT_IMP(a_one_item, take, !busy_r)
  `ASSERT_IMP(a_no_clobber, log_vld, !ov_r)
  `ASSERT_NXT(a_busy_after_take, take, busy_r)
endmodule
`default_nettype wire

// ===== tb/spectrum_power_averager_db_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_power_averager_db_tb
// Self-checking testbench for the spectrum power averager. A short table of
// directed bins runs first. Randomized segment streams follow under several
// register settings, including both extremes of each register. Every result
// transaction is compared field by field with a typed value or an in-bench power/log model.
// ----------------------------------------------------------------------------
module spectrum_power_averager_db_tb;
  import spad_pkg::*;

  localparam logic [1:0] IDX_AVG    = {1'b0, REG_AVG_FACTOR};
  localparam logic [1:0] IDX_LOG2   = {1'b0, REG_LOG2_FFT};
  // The two upper index codes address no register and must be ignored.
  localparam logic [1:0] IDX_UNUSED2 = 2'd2;
  localparam logic [1:0] IDX_UNUSED3 = 2'd3;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  spad_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  spad_out_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [10:0] cfg_data = '0;

  spectrum_power_averager_db dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Model state: a private copy of the registers, the counters and the sums.
  // ---------------------------------------------------------------------------
  logic [10:0] avg_reg;
  logic [3:0]  log2_reg;
  int          bin_pos;
  int          seg_pos;
  logic [35:0] grp_freq;
  bit          grp_mismatch;
  logic [41:0] bin_power [4096];

  spad_out_t expected_psd[$];
  int        error_count = 0;
  int        bins_sent = 0;
  int        results_seen = 0;
  int        mismatch_groups = 0;
  bit        quiet = 1'b0;   // Disables random idling on both sides.

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Appends one expected result at the tail of the queue.
  task automatic queue_expected(input spad_out_t r);
    expected_psd = {expected_psd, r};
  endtask

  // log2(x) in Q16 by repeated squaring of a Q30 mantissa.
  function automatic longint log2_q16(input logic [63:0] x);
    int          e;
    logic [63:0] m;
    longint      frac;
    e = 63;
    frac = 0;
    while (e > 0 && x[e] == 1'b0) e--;
    m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(e) * 65536 + frac;
  endfunction

  function automatic logic signed [15:0] avg_power_db(input logic [41:0] sum, input int avg);
    longint d;
    longint r;
    if (sum == 0) return -16'sd25600;
    d = log2_q16({22'd0, sum}) - log2_q16(64'(avg));
    // Adding one half before the arithmetic shift rounds the product to nearest.
    r = (d * 64'sd50504433 + 64'sd2147483648) >>> 32;
    if (r < -25600) r = -25600;
    if (r > 25600) r = 25600;
    return 16'(r);
  endfunction

  function automatic int eff_log2();
    return (log2_reg < 4) ? 4 : ((log2_reg > LOG2_FFT_MAX) ? LOG2_FFT_MAX : int'(log2_reg));
  endfunction

  function automatic int eff_avg();
    return (avg_reg < 1) ? 1 : ((avg_reg > AVG_MAX) ? AVG_MAX : int'(avg_reg));
  endfunction

  // Advances the model by one accepted bin. Fills res and returns 1 when
  // the bin produces a result transaction; res is filled in either case.
  function automatic bit predict_bin(input spad_in_t it, output spad_out_t res);
    int          size;
    int          avg;
    int          idx;
    logic [41:0] p;
    bit          last_seg;
    bit          last;
    bit          emit;
    size = 1 << eff_log2();
    avg = eff_avg();
    if (bin_pos >= size) bin_pos = 0;
    if (seg_pos >= avg) seg_pos = 0;
    idx = bin_pos;
    if (idx == 0) begin
      if (seg_pos == 0) begin
        grp_freq = it.center_freq;
        grp_mismatch = 1'b0;
      end else if (it.center_freq != grp_freq) begin
        grp_mismatch = 1'b1;
      end
    end
    p = 42'(longint'(it.bin_re) * it.bin_re) + 42'(longint'(it.bin_im) * it.bin_im);
    bin_power[idx] = (seg_pos == 0) ? p : bin_power[idx] + p;
    last_seg = (seg_pos == avg - 1);
    last = (idx == size - 1);
    emit = last_seg && !grp_mismatch;
    if (last_seg && grp_mismatch && last) mismatch_groups++;
    res.psd_db = avg_power_db(bin_power[idx], avg);
    res.bin_index = 12'(idx);
    res.seg_center_freq = grp_freq;
    res.last_bin = last;
    if (last) begin
      bin_pos = 0;
      if (last_seg) begin
        seg_pos = 0;
        grp_mismatch = 1'b0;
      end else begin
        seg_pos++;
      end
    end else begin
      bin_pos++;
    end
    return emit;
  endfunction

  // ---------------------------------------------------------------------------
  // Random idling: mostly short gaps, now and then a long one.
  // ---------------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= gap_len();
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted transaction against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    spad_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_psd.size() == 0) begin
        report_mismatch($sformatf("unexpected result bin %0d", out_data.bin_index));
      end else begin
        want = expected_psd.pop_front();
        if (out_data.psd_db !== want.psd_db)
          report_mismatch($sformatf("bin %0d psd_db got %0d want %0d",
                                    want.bin_index, out_data.psd_db, want.psd_db));
        if (out_data.bin_index !== want.bin_index)
          report_mismatch($sformatf("bin_index got %0d want %0d",
                                    out_data.bin_index, want.bin_index));
        if (out_data.seg_center_freq !== want.seg_center_freq)
          report_mismatch($sformatf("bin %0d seg_center_freq got %0h want %0h",
                                    want.bin_index, out_data.seg_center_freq,
                                    want.seg_center_freq));
        if (out_data.last_bin !== want.last_bin)
          report_mismatch($sformatf("bin %0d last_bin got %0b want %0b",
                                    want.bin_index, out_data.last_bin, want.last_bin));
      end
    end
  end

  // Watchdog: too many cycles without any transaction means a hang.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", expected_psd.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Offers one bin and waits until it is accepted. The valid stays high so
  // back-to-back bins need no dead cycle; a random gap may follow.
  task automatic send_bin(input spad_in_t it, input bit typed, input spad_out_t typed_res);
    spad_out_t res;
    int        g;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    bins_sent++;
    if (predict_bin(it, res)) queue_expected(typed ? typed_res : res);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every expected result has arrived, then
  // lets the pipeline empty of bins that produce nothing.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_psd.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == IDX_AVG || idx == IDX_LOG2) begin
      if (idx == IDX_AVG) avg_reg = val;
      else log2_reg = val[3:0];
      bin_pos = 0;
      seg_pos = 0;
      grp_mismatch = 1'b0;
    end
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(3))
      0: return 16'sd0;
      1: return 16'($urandom);
      2: return 16'($signed($urandom_range(6)) - 3);
      default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  // Builds well-formed segment streams: bin 0 of a later segment repeats the
  // group frequency unless a mismatch is injected; other bins carry noise
  // in the frequency field, which the block ignores.
  task automatic run_segments(input int count, input int mismatch_pct);
    spad_in_t  it;
    spad_out_t none;
    int        pos;
    int        seg;
    none = '0;
    for (int n = 0; n < count; n++) begin
      pos = (bin_pos >= (1 << eff_log2())) ? 0 : bin_pos;
      seg = (seg_pos >= eff_avg()) ? 0 : seg_pos;
      it.bin_re = rand_sample();
      it.bin_im = rand_sample();
      if (pos == 0 && seg == 0) begin
        it.center_freq = 36'({$urandom, $urandom});
      end else if (pos == 0) begin
        it.center_freq = grp_freq;
        if ($urandom_range(99) < mismatch_pct) it.center_freq[$urandom_range(35)] ^= 1'b1;
      end else begin
        it.center_freq = $urandom_range(2) == 0 ? 36'({$urandom, $urandom}) : grp_freq;
      end
      send_bin(it, 1'b0, none);
    end
  endtask

  // Directed rows: the expected result is typed in where it is obvious.
  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    bit                 typed;
    logic signed [15:0] psd;
  } dir_row_t;

  localparam logic [35:0] DIR_FREQ = 36'hA_5C3F_0910;

  dir_row_t dir_rows[] = '{
    '{16'sd0,      16'sd0,      1'b1, -16'sd25600},  // zero power hits the floor
    '{16'sd1,      16'sd0,      1'b1, 16'sd0},       // unit power is 0 dB
    '{16'sd0,      -16'sd1,     1'b1, 16'sd0},
    '{-16'sd1,     16'sd0,      1'b1, 16'sd0},
    '{16'sh7FFF,   16'sh7FFF,   1'b0, 16'sd0},
    '{16'sh8000,   16'sh8000,   1'b0, 16'sd0},       // largest possible power
    '{16'sh8000,   16'sd0,      1'b0, 16'sd0},
    '{16'sd0,      16'sh7FFF,   1'b0, 16'sd0},
    '{16'sh7FFF,   16'sh8000,   1'b0, 16'sd0},
    '{16'sd2,      16'sd0,      1'b0, 16'sd0},
    '{16'sd1,      16'sd1,      1'b0, 16'sd0},
    '{16'sd3,      -16'sd4,     1'b0, 16'sd0},
    '{-16'sd1,     -16'sd1,     1'b0, 16'sd0},
    '{16'sh5555,   16'shAAAA,   1'b0, 16'sd0},
    '{16'shAAAA,   16'sh5555,   1'b0, 16'sd0},
    '{16'sd0,      16'sd0,      1'b1, -16'sd25600},
    '{16'sd181,    16'sd0,      1'b0, 16'sd0},
    '{16'sd0,      -16'sd1000,  1'b0, 16'sd0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    spad_in_t  it;
    spad_out_t typed_res;
    avg_reg = 11'd1;
    log2_reg = 4'd10;
    bin_pos = 0;
    seg_pos = 0;
    grp_freq = '0;
    grp_mismatch = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed bins under the reset settings: one result per bin.
    foreach (dir_rows[i]) begin
      it.bin_re = dir_rows[i].re;
      it.bin_im = dir_rows[i].im;
      it.center_freq = (i == 0) ? DIR_FREQ : ~DIR_FREQ;  // only bin 0 counts
      typed_res.psd_db = dir_rows[i].psd;
      typed_res.bin_index = 12'(i);
      typed_res.seg_center_freq = DIR_FREQ;
      typed_res.last_bin = 1'b0;
      send_bin(it, dir_rows[i].typed, typed_res);
    end

    // Small spectra, groups of three, occasional frequency mismatches.
    write_reg(IDX_AVG, 11'd3);
    write_reg(IDX_LOG2, 11'd4);
    run_segments(100, 15);
    // Writes to unused indexes must not disturb the running group.
    write_reg(IDX_UNUSED2, 11'($urandom));
    write_reg(IDX_UNUSED3, 11'h7FF);
    run_segments(40, 15);

    // Both registers below range: averaging of one, sixteen bins.
    write_reg(IDX_AVG, 11'd0);
    write_reg(IDX_LOG2, 11'd0);
    run_segments(48, 0);

    // Pairs of 32-bin segments, with a full pause in the middle.
    write_reg(IDX_AVG, 11'd2);
    write_reg(IDX_LOG2, 11'd5);
    run_segments(40, 20);
    drain_results();
    run_segments(40, 20);

    // Both registers at and above their tops; the group is cut short.
    write_reg(IDX_AVG, 11'd1024);
    write_reg(IDX_LOG2, 11'hF);
    run_segments(30, 0);

    // Start of the largest spectrum, one result per bin, without idling.
    quiet = 1'b1;
    write_reg(IDX_AVG, 11'd1);
    write_reg(IDX_LOG2, 11'd12);
    run_segments(40, 0);

    // Deepest averaging on the smallest spectrum; the group is cut short.
    write_reg(IDX_AVG, 11'h7FF);
    write_reg(IDX_LOG2, 11'd4);
    run_segments(32, 0);
    quiet = 1'b0;

    // Mixed groups with frequent mismatches and full idling.
    write_reg(IDX_AVG, 11'd5);
    write_reg(IDX_LOG2, 11'd4);
    run_segments(80, 25);
    write_reg(IDX_AVG, 11'd1);
    run_segments(40, 0);

    drain_results();
    $display("Sent %0d bins, checked %0d results, %0d groups dropped on frequency mismatch",
             bins_sent, results_seen, mismatch_groups);
    $display("Settings covered averaging 0..2047 and spectrum sizes 0..15 including unused writes");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/spad_pkg.sv
design/spad_ram.sv
design/spad_log.sv
design/spad_acc.sv
design/spectrum_power_averager_db.sv
tb/spectrum_power_averager_db_tb.sv
